[hdl/rc_pkg.sv]
// Shared types, constants and helper functions for the radix converter.
// No dependencies; rc_if, rc_alu and radix_converter import this package.
package rc_pkg;

  localparam int unsigned RC_WORD_W         = 64;
  localparam int unsigned RC_NUM_W          = 60;
  localparam int unsigned RC_BASE_W         = 4;
  localparam int unsigned RC_DIGIT_W        = 4;
  localparam int unsigned RC_MAX_IN_DIGITS  = 18;
  localparam int unsigned RC_MAX_OUT_DIGITS = 60;

  localparam logic [RC_BASE_W-1:0] RC_BASE_MIN = 4'd2;
  localparam logic [RC_BASE_W-1:0] RC_BASE_MAX = 4'd10;

  // Operands of the shared arithmetic unit
  typedef struct packed {
    logic [RC_WORD_W-1:0]  mul_a;
    logic [RC_BASE_W-1:0]  mul_b;
    logic [RC_DIGIT_W-1:0] mul_c;
    logic [RC_WORD_W-1:0]  sub_x;
    logic [RC_WORD_W-1:0]  sub_y;
    logic                  y_from_prod;
  } alu_in_t;

  typedef struct packed {
    logic [RC_WORD_W-1:0] prod;
    logic [RC_WORD_W-1:0] diff;
    logic                 ge;
  } alu_out_t;

  // Powers of ten up to 10^19, the largest that fits 64 bits
  function automatic logic [RC_WORD_W-1:0] pow10(input logic [4:0] k);
    logic [RC_WORD_W-1:0] r;
    unique case (k)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Highest digit bit needed in a given base: 2^(result+1) >= base
  function automatic logic [1:0] digit_steps(input logic [RC_BASE_W-1:0] base);
    logic [1:0] r;
    priority if (base <= 4'd2) r = 2'd0;
    else if (base <= 4'd4)     r = 2'd1;
    else if (base <= 4'd8)     r = 2'd2;
    else                       r = 2'd3;
    return r;
  endfunction

endpackage

[hdl/rc_if.sv]
// Request and result channels of the radix converter (valid/ready).
// Depends on rc_pkg for the field widths.
interface rc_in_if import rc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RC_NUM_W-1:0]  digit_value;
  logic [RC_BASE_W-1:0] source_base;
  logic [RC_BASE_W-1:0] target_base;

  modport source (output valid, digit_value, source_base, target_base, input ready);
  modport sink   (input valid, digit_value, source_base, target_base, output ready);
endinterface

interface rc_out_if import rc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RC_DIGIT_W-1:0] out_digit;
  logic                  last_digit;
  logic                  bad_request;

  modport source (output valid, out_digit, last_digit, bad_request, input ready);
  modport sink   (input valid, out_digit, last_digit, bad_request, output ready);
endinterface

[hdl/rc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 60,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/rc_alu.sv]
// Shared arithmetic unit: multiply by a 4-bit base and add a digit, and a
// 64-bit compare/subtract whose subtrahend may be the product. Uses rc_pkg.
module rc_alu import rc_pkg::*; (
  input  alu_in_t  op_i,
  output alu_out_t res_o
);

  logic [RC_WORD_W-1:0] pp [RC_BASE_W];
  logic [RC_WORD_W-1:0] y;
  logic [RC_WORD_W:0]   d;

  always_comb begin
    for (int i = 0; i < RC_BASE_W; i++) begin
      pp[i] = op_i.mul_b[i] ? (op_i.mul_a << i) : '0;
    end
    res_o.prod = pp[0] + pp[1] + pp[2] + pp[3] + RC_WORD_W'(op_i.mul_c);
    y          = op_i.y_from_prod ? res_o.prod : op_i.sub_y;
    d          = {1'b0, op_i.sub_x} - {1'b0, y};
    res_o.diff = d[RC_WORD_W-1:0];
    res_o.ge   = ~d[RC_WORD_W];
  end

endmodule

[hdl/radix_converter.sv]
// Radix converter: a request carries a number whose decimal digits are read
// as digits in a source base (2..10); the block returns its digits in a
// target base (2..10), most significant first, the last one flagged, or a
// single bad_request result for a bad base, a digit not below the source
// base, too many input digits or too many output digits. Zero comes back as
// one digit 0. One request is worked at a time and in_i.ready is low while
// it runs. A request is accepted, all MAX_IN_DIGITS decimal digits are
// peeled (four shift/subtract steps against a table of powers of ten plus
// one multiply-add each), a start step writes the first power, the powers
// of the target base are built into the power RAM, then each output digit
// takes one compare/subtract step per digit bit: one for base 2, two for
// bases 3-4, three for 5-8 and four for 9-10; all of it runs through the
// one shared compare/subtract and multiply-add unit. Errors found early
// return sooner; a stalled result channel holds the sequencer. The next
// request is taken while the final result still waits in the output register.
module radix_converter import rc_pkg::*; #(
  parameter int unsigned MAX_IN_DIGITS  = RC_MAX_IN_DIGITS,
  parameter int unsigned MAX_OUT_DIGITS = RC_MAX_OUT_DIGITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rc_in_if.sink    in_i,
  rc_out_if.source out_o
);

  localparam int unsigned KW = (MAX_IN_DIGITS > 1) ? $clog2(MAX_IN_DIGITS) : 1;
  localparam int unsigned AW = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;
  localparam int unsigned NW = $clog2(MAX_OUT_DIGITS + 1);
  localparam logic [RC_WORD_W-1:0] IN_LIMIT = pow10(5'(MAX_IN_DIGITS));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_EVAL,
    ST_POWINIT,
    ST_POWUP,
    ST_DIGIT,
    ST_PUT
  } state_e;

  state_e                state_q, state_d;
  logic [RC_BASE_W-1:0]  sb_q, sb_d;
  logic [RC_BASE_W-1:0]  tb_q, tb_d;
  logic [RC_WORD_W-1:0]  rem_q, rem_d;
  logic [RC_WORD_W-1:0]  value_q, value_d;
  logic [RC_WORD_W-1:0]  p_q, p_d;
  logic [KW-1:0]         k_q, k_d;
  logic [1:0]            s_q, s_d;
  logic [RC_DIGIT_W-1:0] dig_q, dig_d;
  logic [NW-1:0]         n_q, n_d;
  logic [AW-1:0]         j_q, j_d;
  logic                  pend_last_q, pend_last_d;
  logic                  pend_bad_q, pend_bad_d;
  logic                  out_valid_q, out_valid_d;
  logic [RC_DIGIT_W-1:0] out_digit_q, out_digit_d;
  logic                  out_last_q, out_last_d;
  logic                  out_bad_q, out_bad_d;

  alu_in_t               alu_in;
  alu_out_t              alu_out;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RC_WORD_W-1:0]  ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [RC_WORD_W-1:0]  ram_rdata;
  logic                  out_free;
  logic                  bad_base;
  logic [RC_DIGIT_W-1:0] dig_new;

  rc_alu u_alu (
    .op_i  (alu_in),
    .res_o (alu_out)
  );

  // Powers of the target base, lowest first
  rc_ram #(
    .WIDTH (RC_WORD_W),
    .DEPTH (MAX_OUT_DIGITS)
  ) u_pow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.out_digit   = out_digit_q;
  assign out_o.last_digit  = out_last_q;
  assign out_o.bad_request = out_bad_q;

  assign out_free = ~out_valid_q | out_o.ready;
  assign bad_base = (in_i.source_base < RC_BASE_MIN) || (in_i.source_base > RC_BASE_MAX) ||
                    (in_i.target_base < RC_BASE_MIN) || (in_i.target_base > RC_BASE_MAX);

  always_comb begin
    state_d     = state_q;
    sb_d        = sb_q;
    tb_d        = tb_q;
    rem_d       = rem_q;
    value_d     = value_q;
    p_d         = p_q;
    k_d         = k_q;
    s_d         = s_q;
    dig_d       = dig_q;
    n_d         = n_q;
    j_d         = j_q;
    pend_last_d = pend_last_q;
    pend_bad_d  = pend_bad_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    alu_in      = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    dig_new     = dig_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sb_d = in_i.source_base;
          tb_d = in_i.target_base;
          if (bad_base || (RC_WORD_W'(in_i.digit_value) >= IN_LIMIT)) begin
            dig_d       = '0;
            pend_last_d = 1'b1;
            pend_bad_d  = 1'b1;
            state_d     = ST_PUT;
          end else begin
            rem_d   = RC_WORD_W'(in_i.digit_value);
            value_d = '0;
            k_d     = KW'(MAX_IN_DIGITS - 1);
            s_d     = 2'd3;
            dig_d   = '0;
            state_d = ST_DEC;
          end
        end
      end

      // One bit of decimal digit k per cycle, by trial subtraction
      ST_DEC: begin
        alu_in.sub_x = rem_q;
        alu_in.sub_y = pow10(5'(k_q)) << s_q;
        if (alu_out.ge) begin
          rem_d        = alu_out.diff;
          dig_d[s_q]   = 1'b1;
        end
        if (s_q == 2'd0) begin
          state_d = ST_EVAL;
        end else begin
          s_d = s_q - 2'd1;
        end
      end

      // Check the digit and fold it into the value (leading zeros stay zero)
      ST_EVAL: begin
        alu_in.mul_a = value_q;
        alu_in.mul_b = sb_q;
        alu_in.mul_c = dig_q;
        if (dig_q >= sb_q) begin
          dig_d       = '0;
          pend_last_d = 1'b1;
          pend_bad_d  = 1'b1;
          state_d     = ST_PUT;
        end else begin
          value_d = alu_out.prod;
          if (k_q == '0) begin
            state_d = ST_POWINIT;
          end else begin
            k_d     = k_q - KW'(1);
            s_d     = 2'd3;
            dig_d   = '0;
            state_d = ST_DEC;
          end
        end
      end

      ST_POWINIT: begin
        if (value_q == '0) begin
          dig_d       = '0;
          pend_last_d = 1'b1;
          pend_bad_d  = 1'b0;
          state_d     = ST_PUT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = RC_WORD_W'(1);
          p_d       = RC_WORD_W'(1);
          n_d       = NW'(1);
          state_d   = ST_POWUP;
        end
      end

      // Grow powers of the target base while they stay within the value
      ST_POWUP: begin
        alu_in.mul_a       = p_q;
        alu_in.mul_b       = tb_q;
        alu_in.sub_x       = value_q;
        alu_in.y_from_prod = 1'b1;
        if (!alu_out.ge) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(n_q - NW'(1));
          j_d       = AW'(n_q - NW'(1));
          s_d       = digit_steps(tb_q);
          dig_d     = '0;
          state_d   = ST_DIGIT;
        end else if (n_q == NW'(MAX_OUT_DIGITS)) begin
          dig_d       = '0;
          pend_last_d = 1'b1;
          pend_bad_d  = 1'b1;
          state_d     = ST_PUT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(n_q);
          ram_wdata = alu_out.prod;
          p_d       = alu_out.prod;
          n_d       = n_q + NW'(1);
        end
      end

      // One bit of target digit j per cycle vs stored power, unless stalled
      ST_DIGIT: begin
        alu_in.sub_x = value_q;
        alu_in.sub_y = ram_rdata << s_q;
        if (alu_out.ge) begin
          value_d      = alu_out.diff;
          dig_new[s_q] = 1'b1;
        end
        dig_d = dig_new;
        if (s_q != 2'd0) begin
          s_d = s_q - 2'd1;
        end else begin
          pend_last_d = (j_q == '0);
          pend_bad_d  = 1'b0;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_digit_d = dig_new;
            out_last_d  = (j_q == '0);
            out_bad_d   = 1'b0;
            if (j_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = j_q - AW'(1);
              j_d       = j_q - AW'(1);
              s_d       = digit_steps(tb_q);
              dig_d     = '0;
            end
          end else begin
            state_d = ST_PUT;
          end
        end
      end

      // Hold the pending result until the output register frees up
      ST_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = dig_q;
          out_last_d  = pend_last_q;
          out_bad_d   = pend_bad_q;
          if (pend_last_q) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = j_q - AW'(1);
            j_d       = j_q - AW'(1);
            s_d       = digit_steps(tb_q);
            dig_d     = '0;
            state_d   = ST_DIGIT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sb_q        <= '0;
      tb_q        <= '0;
      rem_q       <= '0;
      value_q     <= '0;
      p_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
      dig_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
      pend_last_q <= 1'b0;
      pend_bad_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_digit_q <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      sb_q        <= sb_d;
      tb_q        <= tb_d;
      rem_q       <= rem_d;
      value_q     <= value_d;
      p_q         <= p_d;
      k_q         <= k_d;
      s_q         <= s_d;
      dig_q       <= dig_d;
      n_q         <= n_d;
      j_q         <= j_d;
      pend_last_q <= pend_last_d;
      pend_bad_q  <= pend_bad_d;
      out_valid_q <= out_valid_d;
      out_digit_q <= out_digit_d;
      out_last_q  <= out_last_d;
      out_bad_q   <= out_bad_d;
    end
  end

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_request |-> out_o.last_digit && (out_o.out_digit == '0))
    else $error("error result not a single zero digit marked last");

  a_pow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_OUT_DIGITS))
    else $error("power count beyond RAM depth");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |->
      ({1'b0, value_q} < (({1'b0, ram_rdata} << s_q) << 1)))
    else $error("remainder too large for the digit bits left");

endmodule
